FILE: sv/assert_macros.svh
// Assertion macros for the queue modules; bfq_ring includes them.
// The macros expect signals named clk and rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

FILE: sv/bfq_pkg.sv
// Shared constants, codes, types and helpers of the bounded frame queue.
// Used by bfq_ring, bfq_stats and the top level; depends on nothing.
`default_nettype none

package bfq_pkg;

  localparam int DEPTH        = 16;
  localparam int PTR_BITS     = $clog2(DEPTH);
  localparam int COUNT_BITS   = $clog2(DEPTH + 1);
  localparam int SUM_BITS     = COUNT_BITS + 1;
  localparam int PAYLOAD_BITS = 32;
  localparam int CNT_BITS     = 32;
  localparam int STATUS_BITS  = 2;

  localparam int CAP_BITS        = 5;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 5;

  localparam int S_FIELD_BITS = PAYLOAD_BITS + 1;
  localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;
  localparam int M_FIELD_BITS = PAYLOAD_BITS + 2 * COUNT_BITS + 5 * CNT_BITS;
  localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;
  localparam int M_TUSER_BITS = STATUS_BITS + 1;

  localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_REJECTED = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd2;

  localparam logic OP_SUBMIT  = 1'b0;
  localparam logic OP_CONSUME = 1'b1;

  localparam logic POLICY_DROP   = 1'b0;
  localparam logic POLICY_REJECT = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_POLICY   = 2'd1;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(DEPTH);

  typedef struct packed {
    logic [CAP_BITS-1:0] capacity;
    logic                policy;
  } bfq_cfg_t;

  typedef struct packed {
    logic append;
    logic reject;
    logic drop;
    logic consume;
    logic fail;
  } bfq_events_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]  status;
    logic                    popped_valid;
  } bfq_result_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] accepted;
    logic [CNT_BITS-1:0] rejected;
    logic [CNT_BITS-1:0] dropped;
    logic [CNT_BITS-1:0] consumed;
    logic [CNT_BITS-1:0] failed;
  } bfq_totals_t;

  function automatic logic [PTR_BITS-1:0] ring_next(input logic [PTR_BITS-1:0] i);
    logic [PTR_BITS-1:0] n;
    if (i == PTR_BITS'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = i + PTR_BITS'(1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: sv/bounded_frame_queue_drop_policy.sv
// Top level of the bounded frame queue: input register, result register,
// configuration registers. Depends on bfq_pkg, bfq_ring and bfq_stats.
//
//   channel   direction  handshake           contents
//   s_*       in         s_tvalid/s_tready   submit or consume word
//   m_*       out        m_tvalid/m_tready   one result word per input word
//   cfg_*     in         cfg_valid/cfg_ready capacity and full policy writes
//
// One word per cycle is sustained while m_tready is high; a result word is
// presented after its input word passes the input and result registers.
// The ring store, pointers and counters update in the same cycle as the result.
// Reset clears pointers, counts and counters and sets capacity 16, drop oldest;
// the store contents are not cleared. With m_tready low the result is held,
// one further word is taken into the input register and then s_tready falls.
`default_nettype none

module bounded_frame_queue_drop_policy (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  input  wire  [bfq_pkg::S_TDATA_BITS-1:0]     s_tdata,  // payload, downstream_ok, zeros
  input  wire                                  s_tuser,  // operation
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  // popped_payload, pending_count, high_watermark, accepted_total, rejected_total,
  // dropped_total, consumed_total, failed_total, zeros
  output logic [bfq_pkg::M_TDATA_BITS-1:0]     m_tdata,
  output logic [bfq_pkg::M_TUSER_BITS-1:0]     m_tuser,  // status, popped_valid
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [bfq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire  [bfq_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  logic                             in_valid;
  logic                             in_op;
  logic [bfq_pkg::PAYLOAD_BITS-1:0] in_payload;
  logic                             in_ok;
  logic                             fire;
  logic                             out_valid;
  bfq_pkg::bfq_result_t             out_res;
  bfq_pkg::bfq_result_t             res;
  bfq_pkg::bfq_events_t             ev;
  bfq_pkg::bfq_cfg_t                cfg;
  bfq_pkg::bfq_totals_t             totals;
  logic [bfq_pkg::PAYLOAD_BITS-1:0] popped;
  logic [bfq_pkg::COUNT_BITS-1:0]   count;
  logic [bfq_pkg::COUNT_BITS-1:0]   count_next;
  logic [bfq_pkg::COUNT_BITS-1:0]   peak;

  assign fire      = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op      <= s_tuser;
      in_payload <= s_tdata[bfq_pkg::PAYLOAD_BITS-1:0];
      in_ok      <= s_tdata[bfq_pkg::PAYLOAD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity <= bfq_pkg::CAP_RESET;
      cfg.policy   <= bfq_pkg::POLICY_DROP;
    end else if (cfg_valid) begin
      case (cfg_index)
        bfq_pkg::CFG_CAPACITY: cfg.capacity <= cfg_data[bfq_pkg::CAP_BITS-1:0];
        bfq_pkg::CFG_POLICY:   cfg.policy   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  bfq_ring u_ring (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .op            (in_op),
    .payload       (in_payload),
    .downstream_ok (in_ok),
    .cfg           (cfg),
    .ev            (ev),
    .res           (res),
    .popped        (popped),
    .count         (count),
    .count_next    (count_next)
  );

  bfq_stats u_stats (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .ev         (ev),
    .count_next (count_next),
    .peak       (peak),
    .totals     (totals)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  // Queue state only changes when a new result replaces the one on the
  // port, so the counts and totals are read straight from their registers.
  assign m_tvalid = out_valid;
  assign m_tuser  = {out_res.popped_valid, out_res.status};
  assign m_tdata  = {{(bfq_pkg::M_TDATA_BITS - bfq_pkg::M_FIELD_BITS){1'b0}},
                     totals.failed, totals.consumed, totals.dropped,
                     totals.rejected, totals.accepted,
                     peak, count, popped};

endmodule

`default_nettype wire

FILE: sv/bfq_ring.sv
// Ring store, head pointer and occupancy of the frame queue, with the
// per-word decision logic. Depends on bfq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bfq_ring (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 fire,
  input  wire                                 op,
  input  wire  [bfq_pkg::PAYLOAD_BITS-1:0]    payload,
  input  wire                                 downstream_ok,
  input  bfq_pkg::bfq_cfg_t                   cfg,
  output bfq_pkg::bfq_events_t                ev,
  output bfq_pkg::bfq_result_t                res,
  output logic [bfq_pkg::PAYLOAD_BITS-1:0]    popped,
  output logic [bfq_pkg::COUNT_BITS-1:0]      count,
  output logic [bfq_pkg::COUNT_BITS-1:0]      count_next
);

  logic [bfq_pkg::PAYLOAD_BITS-1:0] store [bfq_pkg::DEPTH];
  logic [bfq_pkg::PTR_BITS-1:0]     head;
  logic [bfq_pkg::PTR_BITS-1:0]     head_next;
  logic [bfq_pkg::COUNT_BITS-1:0]   cap_eff;
  logic [bfq_pkg::SUM_BITS-1:0]     tail_sum;
  logic [bfq_pkg::SUM_BITS-1:0]     tail_wrap;
  logic [bfq_pkg::PTR_BITS-1:0]     tail;
  logic                             full;
  logic                             wr;

  always_comb begin
    if (cfg.capacity == '0) begin
      cap_eff = bfq_pkg::COUNT_BITS'(1);
    end else if (bfq_pkg::SUM_BITS'(cfg.capacity) > bfq_pkg::SUM_BITS'(bfq_pkg::DEPTH)) begin
      cap_eff = bfq_pkg::COUNT_BITS'(bfq_pkg::DEPTH);
    end else begin
      cap_eff = bfq_pkg::COUNT_BITS'(cfg.capacity);
    end
  end

  assign full = (count >= cap_eff);

  // With a drop the head moves on by one and the count falls by one before
  // the append, so the tail slot is the same as for a plain append.
  always_comb begin
    tail_sum = bfq_pkg::SUM_BITS'(count) + bfq_pkg::SUM_BITS'(head);
    if (tail_sum >= bfq_pkg::SUM_BITS'(bfq_pkg::DEPTH)) begin
      tail_wrap = tail_sum - bfq_pkg::SUM_BITS'(bfq_pkg::DEPTH);
    end else begin
      tail_wrap = tail_sum;
    end
    tail = tail_wrap[bfq_pkg::PTR_BITS-1:0];
  end

  always_comb begin
    ev                 = '0;
    res.status         = bfq_pkg::ST_OK;
    res.popped_valid   = 1'b0;
    head_next          = head;
    count_next         = count;
    wr                 = 1'b0;
    if (op == bfq_pkg::OP_SUBMIT) begin
      if (full && (cfg.policy == bfq_pkg::POLICY_REJECT)) begin
        ev.reject  = 1'b1;
        res.status = bfq_pkg::ST_REJECTED;
      end else begin
        wr        = 1'b1;
        ev.append = 1'b1;
        if (full) begin
          ev.drop   = 1'b1;
          head_next = bfq_pkg::ring_next(head);
        end else begin
          count_next = count + bfq_pkg::COUNT_BITS'(1);
        end
      end
    end else begin
      if (count == '0) begin
        res.status = bfq_pkg::ST_EMPTY;
      end else begin
        res.popped_valid   = 1'b1;
        head_next          = bfq_pkg::ring_next(head);
        count_next         = count - bfq_pkg::COUNT_BITS'(1);
        if (downstream_ok) begin
          ev.consume = 1'b1;
        end else begin
          ev.fail = 1'b1;
        end
      end
    end
  end

  // The popped word is registered alongside the result word and reads as
  // zero when the word pops nothing.
  always_ff @(posedge clk) begin
    if (fire && wr) begin
      store[tail] <= payload;
    end
    if (fire) begin
      if (res.popped_valid) begin
        popped <= store[head];
      end else begin
        popped <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (fire) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= bfq_pkg::COUNT_BITS'(bfq_pkg::DEPTH),
                 "occupancy above depth")
  `ASSERT_NEXT(a_reject_hold, fire && ev.reject,
               count == $past(count) && head == $past(head), "reject moved the queue")
  `ASSERT_NEXT(a_pop_count, fire && (ev.consume || ev.fail),
               count == $past(count) - bfq_pkg::COUNT_BITS'(1), "pop did not lower the count")
  `ASSERT_ALWAYS(a_drop_full, !(ev.drop && !full), "drop while not full")

endmodule

`default_nettype wire

FILE: sv/bfq_stats.sv
// Event counters and occupancy high watermark of the frame queue.
// Depends on bfq_pkg.
`default_nettype none

module bfq_stats (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 fire,
  input  bfq_pkg::bfq_events_t                ev,
  input  wire  [bfq_pkg::COUNT_BITS-1:0]      count_next,
  output logic [bfq_pkg::COUNT_BITS-1:0]      peak,
  output bfq_pkg::bfq_totals_t                totals
);

  always_ff @(posedge clk) begin
    if (rst) begin
      peak   <= '0;
      totals <= '0;
    end else if (fire) begin
      if (count_next > peak) begin
        peak <= count_next;
      end
      if (ev.append) begin
        totals.accepted <= totals.accepted + bfq_pkg::CNT_BITS'(1);
      end
      if (ev.reject) begin
        totals.rejected <= totals.rejected + bfq_pkg::CNT_BITS'(1);
      end
      if (ev.drop) begin
        totals.dropped <= totals.dropped + bfq_pkg::CNT_BITS'(1);
      end
      if (ev.consume) begin
        totals.consumed <= totals.consumed + bfq_pkg::CNT_BITS'(1);
      end
      if (ev.fail) begin
        totals.failed <= totals.failed + bfq_pkg::CNT_BITS'(1);
      end
    end
  end

endmodule

`default_nettype wire
